// ===== design/sha256sh_pkg.sv =====
// Shared types, constants and functions of the SHA-256 stream hasher.
// No dependencies; every other file of the block but the channel interfaces imports it.
package sha256sh_pkg;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;

  // Index 0 holds H0.
  localparam logic [0:7][31:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic      push;
    byte_sel_e byte_sel;
    logic [2:0] len_idx;
    logic      count_inc;
    logic      count_clr;
    logic      load;
    logic      round;
    logic      fold;
    logic      rotate;
    logic      reinit;
    logic [5:0] round_idx;
  } dp_ctl_t;

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ===== design/sha256sh_stream_if.sv =====
// Valid/ready channel interfaces for the byte input and the digest output.
// Depends on nothing; used by the top level of the hasher.
interface sha256sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       msg_end;

  modport source (output valid, output data_byte, output has_byte, output msg_end,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input msg_end,
                output ready);
endinterface

interface sha256sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_done;

  modport source (output valid, output digest_word, output word_index,
                  output digest_done, input ready);
  modport sink (input valid, input digest_word, input word_index, input digest_done,
                output ready);
endinterface

// ===== design/sha256sh_sched.sv =====
// Block buffer and message schedule window of the hasher.
// Depends on sha256sh_pkg for the schedule sigma functions.
module sha256sh_sched
  import sha256sh_pkg::*;
(
  input  logic        clk_i,
  input  logic        push_i,
  input  logic [7:0]  byte_i,
  input  logic        round_i,
  output logic [31:0] w_o
);

  // Word k of the window sits at bits 511-32k down; word 0 is W[t] in a round.
  logic [511:0] blk_q, blk_d;
  logic [31:0]  w_next;

  always_comb begin
    w_next = small_sig1(blk_q[511-14*32 -: 32]) + blk_q[511-9*32 -: 32]
           + small_sig0(blk_q[511-1*32 -: 32]) + blk_q[511 -: 32];
    blk_d = blk_q;
    if (push_i) begin
      blk_d = {blk_q[503:0], byte_i};
    end else if (round_i) begin
      blk_d = {blk_q[479:0], w_next};
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  assign w_o = blk_q[511 -: 32];

endmodule

// ===== design/sha256sh_round.sv =====
// Round unit of the hasher: working variables a..h, chaining state, and the
// shared compression round. Depends on sha256sh_pkg.
module sha256sh_round
  import sha256sh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_ctl_t     ctl_i,
  input  logic [31:0] w_i,
  output logic [31:0] head_word_o
);

  logic [0:7][31:0] vars_q, vars_d;
  logic [0:7][31:0] chain_q, chain_d;
  logic [31:0]      t1, t2;

  always_comb begin
    t1 = vars_q[7] + big_sig1(vars_q[4])
       + ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]))
       + round_const(ctl_i.round_idx) + w_i;
    t2 = big_sig0(vars_q[0])
       + ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
    vars_d = vars_q;
    if (ctl_i.load) begin
      vars_d = chain_q;
    end else if (ctl_i.round) begin
      vars_d = {t1 + t2, vars_q[0], vars_q[1], vars_q[2],
                vars_q[3] + t1, vars_q[4], vars_q[5], vars_q[6]};
    end
  end

  always_comb begin
    chain_d = chain_q;
    priority if (ctl_i.reinit) begin
      chain_d = INIT_HASH;
    end else if (ctl_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = chain_q[i] + vars_q[i];
      end
    end else if (ctl_i.rotate) begin
      // The digest leaves word by word from the head of the chaining state.
      chain_d = {chain_q[1:7], chain_q[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= INIT_HASH;
    end else begin
      chain_q <= chain_d;
    end
  end

  assign head_word_o = chain_q[0];

endmodule

// ===== design/sha256sh_ctrl.sv =====
// Sequencer of the hasher: byte intake, padding, rounds and digest output.
// Depends on sha256sh_pkg for the state and control types.
module sha256sh_ctrl
  import sha256sh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_has_byte_i,
  input  logic       in_msg_end_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] word_index_o,
  output logic       digest_done_o,
  output dp_ctl_t    ctl_o
);

  state_e     state_q, state_d;
  logic [5:0] fill_q, fill_d;
  logic [5:0] round_q, round_d;
  logic [2:0] len_idx_q, len_idx_d;
  logic [2:0] out_idx_q, out_idx_d;
  logic       end_pend_q, end_pend_d;
  logic       mark_q, mark_d;
  logic       len_on_q, len_on_d;
  logic       pad_done_q, pad_done_d;
  logic       accept, push, wrap, out_xfer, last_xfer;
  byte_sel_e  pad_sel;

  assign accept    = (state_q == ST_IDLE) && in_valid_i;
  assign push      = (accept && in_has_byte_i) || (state_q == ST_PAD);
  assign wrap      = push && (fill_q == LAST_BYTE);
  assign out_xfer  = (state_q == ST_EMIT) && out_ready_i;
  assign last_xfer = out_xfer && (out_idx_q == LAST_WORD);

  always_comb begin
    if (!mark_q) begin
      pad_sel = SEL_MARK;
    end else if (!len_on_q && fill_q != LEN_POS) begin
      pad_sel = SEL_ZERO;
    end else begin
      pad_sel = SEL_LEN;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_has_byte_i && wrap) begin
            state_d = ST_LOAD;
          end else if (in_msg_end_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_LOAD:  state_d = ST_ROUND;
      ST_ROUND: begin
        if (round_q == LAST_ROUND) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (pad_done_q) begin
          state_d = ST_EMIT;
        end else if (end_pend_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (wrap) begin
          state_d = ST_LOAD;
        end
      end
      ST_EMIT: begin
        if (last_xfer) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and counters.
  always_comb begin
    ctl_o = '0;
    ctl_o.push      = push;
    ctl_o.byte_sel  = (state_q == ST_PAD) ? pad_sel : SEL_DATA;
    ctl_o.len_idx   = len_idx_q;
    ctl_o.count_inc = accept && in_has_byte_i;
    ctl_o.count_clr = last_xfer;
    ctl_o.load      = (state_q == ST_LOAD);
    ctl_o.round     = (state_q == ST_ROUND);
    ctl_o.fold      = (state_q == ST_FOLD);
    ctl_o.rotate    = out_xfer;
    ctl_o.reinit    = last_xfer;
    ctl_o.round_idx = round_q;

    in_ready_o    = (state_q == ST_IDLE);
    out_valid_o   = (state_q == ST_EMIT);
    word_index_o  = out_idx_q;
    digest_done_o = (out_idx_q == LAST_WORD);

    fill_d     = push ? fill_q + 6'd1 : fill_q;
    round_d    = (state_q == ST_ROUND) ? round_q + 6'd1 : 6'd0;
    out_idx_d  = out_xfer ? out_idx_q + 3'd1 : out_idx_q;
    end_pend_d = accept ? in_msg_end_i : end_pend_q;
    mark_d     = mark_q;
    len_on_d   = len_on_q;
    len_idx_d  = len_idx_q;
    pad_done_d = pad_done_q;
    if (state_q == ST_PAD) begin
      mark_d = 1'b1;
      if (pad_sel == SEL_LEN) begin
        len_on_d  = 1'b1;
        len_idx_d = len_idx_q + 3'd1;
        if (len_idx_q == LAST_WORD) begin
          pad_done_d = 1'b1;
        end
      end
    end
    if (last_xfer) begin
      end_pend_d = 1'b0;
      mark_d     = 1'b0;
      len_on_d   = 1'b0;
      len_idx_d  = 3'd0;
      pad_done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= 6'd0;
      round_q    <= 6'd0;
      len_idx_q  <= 3'd0;
      out_idx_q  <= 3'd0;
      end_pend_q <= 1'b0;
      mark_q     <= 1'b0;
      len_on_q   <= 1'b0;
      pad_done_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      round_q    <= round_d;
      len_idx_q  <= len_idx_d;
      out_idx_q  <= out_idx_d;
      end_pend_q <= end_pend_d;
      mark_q     <= mark_d;
      len_on_q   <= len_on_d;
      pad_done_q <= pad_done_d;
    end
  end

endmodule

// ===== design/sha256_stream_hasher_core.sv =====
// Top level of the SHA-256 stream hasher: channels, length counter, byte mux.
// Depends on sha256sh_pkg, the channel interfaces, and the ctrl/sched/round units.
//
//   channel  dir  payload                                  transfer
//   in_i     in   data_byte[8] has_byte[1] msg_end[1]       valid && ready
//   out_o    out  digest_word[32] word_index[3] digest_done valid && ready
//
// The 64th byte of a block starts a compression: a load, 64 rounds on the shared
// round unit and the chaining add. A message end pushes padding at one byte per
// cycle except while a block compresses, compresses one or two blocks,
// then offers the eight digest words, one per output transfer.
// Input ready is low while a block compresses and from a message end until the
// last digest transfer; a stalled output simply holds the current word. Reset is
// asynchronous and restores the initial hash values and an empty message.
module sha256_stream_hasher_core
  import sha256sh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sha256sh_in_if.sink    in_i,
  sha256sh_out_if.source out_o
);

  dp_ctl_t     ctl;
  logic [63:0] bit_count_q, bit_count_d;
  logic [7:0]  push_byte;
  logic [7:0]  len_byte;
  logic [31:0] w_t;

  assign len_byte = bit_count_q[{3'd7 - ctl.len_idx, 3'b000} +: 8];

  always_comb begin
    unique case (ctl.byte_sel)
      SEL_DATA: push_byte = in_i.data_byte;
      SEL_MARK: push_byte = PAD_MARK;
      SEL_ZERO: push_byte = 8'h00;
      SEL_LEN:  push_byte = len_byte;
      default:  push_byte = 8'h00;
    endcase
  end

  always_comb begin
    bit_count_d = bit_count_q;
    if (ctl.count_clr) begin
      bit_count_d = 64'd0;
    end else if (ctl.count_inc) begin
      bit_count_d = bit_count_q + 64'd8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q <= 64'd0;
    end else begin
      bit_count_q <= bit_count_d;
    end
  end

  sha256sh_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_has_byte_i (in_i.has_byte),
    .in_msg_end_i  (in_i.msg_end),
    .in_ready_o    (in_i.ready),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .word_index_o  (out_o.word_index),
    .digest_done_o (out_o.digest_done),
    .ctl_o         (ctl)
  );

  sha256sh_sched u_sched (
    .clk_i   (clk_i),
    .push_i  (ctl.push),
    .byte_i  (push_byte),
    .round_i (ctl.round),
    .w_o     (w_t)
  );

  sha256sh_round u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .w_i         (w_t),
    .head_word_o (out_o.digest_word)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for sha256_stream_hasher_core: byte messages in, digest words out.
// Depends on sha256sh_pkg, the channel interfaces, and the hasher RTL.
`timescale 1ns / 1ps

module tb_top;
  import sha256sh_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 600;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eom;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        done;
  } digest_word_t;

  logic clk_i;
  logic rst_ni;

  sha256sh_in_if  in_ch();
  sha256sh_out_if out_ch();

  sha256_stream_hasher_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  byte_item_t   item_q[$];
  digest_word_t digest_q[$];

  // Hash state of the message being predicted.
  logic [31:0] hash_st [8];
  logic [31:0] blk [16];
  logic [63:0] msg_bits;
  logic [5:0]  blk_fill;

  bit in_fire, out_fire;
  bit steady_in, steady_out;
  int in_gap, out_stall, hold_cnt;
  bit held_once;
  int quiet_cycles, pace_cnt;
  int mismatches, words_checked, digests_out;
  int stim_items, msgs_queued, longest_msg;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic int pick_gap(input bit steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One 64-round compression of the current block into the chaining state.
  task automatic sha_round_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, x15, x2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        x15 = w[(r + 1) % 16];
        x2 = w[(r + 14) % 16];
        wt = w[r % 16] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3)) + w[(r + 9) % 16]
           + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
        w[r % 16] = wt;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + wt;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
  endtask

  task automatic take_byte(input logic [7:0] b);
    blk[blk_fill[5:2]][8 * (3 - blk_fill[1:0]) +: 8] = b;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) sha_round_block();
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_st[i] = INIT_HASH[i];
    msg_bits = '0;
    blk_fill = '0;
  endtask

  // Predicts the digest words caused by one accepted input transfer.
  task automatic hash_item(input byte_item_t it);
    logic [63:0] len;
    digest_word_t dw;
    if (it.has) begin
      take_byte(it.data);
      msg_bits = msg_bits + 64'd8;
    end
    if (it.eom) begin
      len = msg_bits;
      take_byte(PAD_MARK);
      while (blk_fill != LEN_POS) take_byte(8'h00);
      for (int i = 0; i < 8; i++) take_byte(len[8 * (7 - i) +: 8]);
      for (int i = 0; i < 8; i++) begin
        dw.word = hash_st[i];
        dw.idx = 3'(i);
        dw.done = (3'(i) == LAST_WORD);
        digest_q.push_back(dw);
      end
      restart_message();
    end
  endtask

  // Queues a message of random bytes; the end flag rides on the last byte or on
  // an item of its own, and ignored filler items may be mixed in.
  task automatic queue_message(input int len, input bit joined, input int noise_pct);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        it.data = 8'($urandom);
        it.has = 1'b0;
        it.eom = 1'b0;
        item_q.push_back(it);
        stim_items++;
      end
      it.data = 8'($urandom);
      it.has = 1'b1;
      it.eom = joined && (i == len - 1);
      item_q.push_back(it);
      stim_items++;
    end
    if (!joined || len == 0) begin
      it.data = 8'($urandom);
      it.has = 1'b0;
      it.eom = 1'b1;
      item_q.push_back(it);
      stim_items++;
    end
    msgs_queued++;
    if (len > longest_msg) longest_msg = len;
  endtask

  // Input driver: a new item is offered at the falling edge after the previous
  // transfer, once the random gap has run out.
  always @(negedge clk_i) begin : drive_in
    byte_item_t nxt;
    logic drive;
    if (rst_ni) begin
      drive = in_ch.valid && !in_fire;
      if (!drive) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (item_q.size() > 0) begin
          nxt = item_q.pop_front();
          in_ch.data_byte <= nxt.data;
          in_ch.has_byte <= nxt.has;
          in_ch.msg_end <= nxt.eom;
          drive = 1'b1;
          in_gap = pick_gap(steady_in);
        end
      end
      in_ch.valid <= drive;
    end
  end

  // Output ready with random stalls; a long hold-off overrides it.
  always @(negedge clk_i) begin : drive_ready
    int s;
    if (rst_ni) begin
      s = out_stall;
      if (out_fire) s = pick_gap(steady_out);
      else if (s > 0) s--;
      out_stall = s;
      out_ch.ready <= (s == 0) && (hold_cnt == 0);
    end
  end

  // Once three digests have passed, the receiver holds off while a digest is
  // offered, which keeps the input stalled while items keep being offered.
  always @(negedge clk_i) begin : long_hold
    if (!held_once && digests_out >= 3 && out_ch.valid) begin
      held_once <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk_i) begin : pace
    pace_cnt++;
    if (pace_cnt % 200 == 0) begin
      steady_in = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor: predicts on every input transfer and checks every output transfer.
  always @(posedge clk_i) begin : watch_ports
    digest_word_t want;
    in_fire = rst_ni && in_ch.valid && in_ch.ready;
    out_fire = rst_ni && out_ch.valid && out_ch.ready;
    if (in_fire) hash_item('{in_ch.data_byte, in_ch.has_byte, in_ch.msg_end});
    if (out_fire) begin
      words_checked++;
      if (out_ch.digest_done) digests_out++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h index %0d done %b", out_ch.digest_word,
                   out_ch.word_index, out_ch.digest_done);
      end else begin
        want = digest_q.pop_front();
        if (out_ch.digest_word !== want.word || out_ch.word_index !== want.idx ||
            out_ch.digest_done !== want.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected %h idx %0d done %b, got %h idx %0d done %b",
                     want.word, want.idx, want.done, out_ch.digest_word,
                     out_ch.word_index, out_ch.digest_done);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d digest words outstanding",
                 STALL_LIMIT, digest_q.size());
        $display("sha256_stream_hasher_core verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    byte_item_t it;
    int roll, len;
    int boundary_len [10];
    boundary_len = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 128};
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte = 1'b0;
    in_ch.msg_end = 1'b0;
    out_ch.ready = 1'b0;
    restart_message();

    // Directed: empty message, ignored filler, byte and end together, extreme
    // byte values with a separate end, and lone zero and 0x80 bytes.
    item_q.push_back('{8'hff, 1'b0, 1'b1});
    item_q.push_back('{8'hff, 1'b0, 1'b0});
    item_q.push_back('{8'h61, 1'b1, 1'b0});
    item_q.push_back('{8'h62, 1'b1, 1'b0});
    item_q.push_back('{8'h63, 1'b1, 1'b1});
    item_q.push_back('{8'hff, 1'b1, 1'b0});
    item_q.push_back('{8'h00, 1'b1, 1'b0});
    item_q.push_back('{8'h00, 1'b0, 1'b1});
    item_q.push_back('{8'h00, 1'b1, 1'b1});
    item_q.push_back('{8'h80, 1'b1, 1'b1});
    stim_items = 10;
    msgs_queued = 5;
    longest_msg = 3;

    // Random messages, biased toward lengths where the padding changes shape.
    while (stim_items < 409 || msgs_queued < 25) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) len = $urandom_range(0, 12);
      else if (roll < 80) len = boundary_len[$urandom_range(0, 9)];
      else len = $urandom_range(13, 130);
      queue_message(len, $urandom_range(0, 1), ($urandom_range(0, 3) == 0) ? 8 : 0);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (item_q.size() != 0 || in_ch.valid || digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Covered %0d input items in %0d messages (longest %0d bytes), one long stall.",
             stim_items, msgs_queued, longest_msg);
    $display("Checked %0d digest words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("sha256_stream_hasher_core verification clean");
    end else begin
      $display("sha256_stream_hasher_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sha256sh_pkg.sv
design/sha256sh_stream_if.sv
design/sha256sh_sched.sv
design/sha256sh_round.sv
design/sha256sh_ctrl.sv
design/sha256_stream_hasher_core.sv
tb/tb_top.sv
